// ===== design/qsed_pkg.sv =====
// ----------------------------------------------------------------------------
// qsed_pkg: shared types and constants of the quoted string escape decoder
// Character codes, decoder modes, result records and queue entry layout.
// ----------------------------------------------------------------------------
package qsed_pkg;

  // Maximum string length in bytes, including the terminator slot
  localparam int MAX_LEN = 256;
  // Output byte counter width: holds 0 .. MAX_LEN-1
  localparam int CNT_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN - 1);

  // Result queue depth (power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // Decoder mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  // Kind of event raised by one input byte
  typedef enum logic {
    EV_BYTE  = 1'b0,
    EV_CLOSE = 1'b1
  } ev_kind_t;

  // One result record
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       too_long;
    logic       last_of_run;
  } res_t;

  // All results caused by one input transaction
  typedef struct packed {
    logic [1:0]     n;
    res_t [2:0]     res;
  } run_t;

  // Queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/qsed_in_if.sv =====
// ----------------------------------------------------------------------------
// qsed_in_if: raw byte channel
// Valid/ready channel carrying one token byte and its start/end marks.
// ----------------------------------------------------------------------------
interface qsed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;
  logic       string_end;

  modport source (output valid, output in_byte, output string_start,
                  output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_start,
                  input string_end, output ready);
endinterface

// ===== design/qsed_out_if.sv =====
// ----------------------------------------------------------------------------
// qsed_out_if: decoded byte channel
// Valid/ready channel carrying one decoded result record.
// ----------------------------------------------------------------------------
interface qsed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic       too_long;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, output too_long, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_string, input too_long, input last_of_run,
                  output ready);
endinterface

// ===== design/qsed_front.sv =====
// ----------------------------------------------------------------------------
// qsed_front: byte classifier
// Accepts raw bytes, tracks escape/octal mode and the length count, and
// builds the run of up to three results each byte causes.
// ----------------------------------------------------------------------------
module qsed_front (
  input  logic                  clk,
  input  logic                  rst_n,
  qsed_in_if.sink               in_chan,
  input  qsed_pkg::q_status_t   q_stat,
  output logic                  push,
  output qsed_pkg::run_t        push_run
);

  qsed_pkg::mode_t        mode_r, mode_nxt;
  logic [7:0]             oct_val_r, oct_val_nxt;
  logic [1:0]             oct_cnt_r, oct_cnt_nxt;
  logic [qsed_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   exc_r, exc_nxt;

  qsed_pkg::ev_kind_t     ev_kind [3];
  logic [7:0]             ev_val  [3];
  logic [1:0]             ev_n;

  logic                   accept;
  logic                   is_oct;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !q_stat.full;
  assign is_oct        = (in_chan.in_byte >= qsed_pkg::CH_0) &&
                         (in_chan.in_byte <= qsed_pkg::CH_7);

  // Mode decode: list the bytes and the close this transaction raises
  always_comb begin
    logic [7:0] c;
    logic       go;
    c           = in_chan.in_byte;
    ev_n        = 2'd0;
    ev_kind     = '{default: qsed_pkg::EV_BYTE};
    ev_val      = '{default: 8'd0};
    mode_nxt    = in_chan.string_start ? qsed_pkg::MODE_TEXT : mode_r;
    oct_val_nxt = in_chan.string_start ? 8'd0 : oct_val_r;
    oct_cnt_nxt = in_chan.string_start ? 2'd0 : oct_cnt_r;
    // opening quote of a new token is skipped
    go          = !(in_chan.string_start && (c == qsed_pkg::CH_QUOTE));

    // octal run in progress
    if (go && (mode_nxt == qsed_pkg::MODE_OCT)) begin
      if (is_oct) begin
        oct_val_nxt = {oct_val_nxt[4:0], c[2:0]};
        oct_cnt_nxt = oct_cnt_nxt + 2'd1;
        if (oct_cnt_nxt == 2'd3) begin
          ev_kind[ev_n] = qsed_pkg::EV_BYTE;
          ev_val[ev_n]  = oct_val_nxt;
          ev_n          = ev_n + 2'd1;
          oct_val_nxt   = 8'd0;
          oct_cnt_nxt   = 2'd0;
          mode_nxt      = qsed_pkg::MODE_TEXT;
        end
        go = 1'b0;
      end else begin
        // short run: flush it, then treat this byte as text
        ev_kind[ev_n] = qsed_pkg::EV_BYTE;
        ev_val[ev_n]  = oct_val_nxt;
        ev_n          = ev_n + 2'd1;
        oct_val_nxt   = 8'd0;
        oct_cnt_nxt   = 2'd0;
        mode_nxt      = qsed_pkg::MODE_TEXT;
      end
    end

    if (go) begin
      if (mode_nxt == qsed_pkg::MODE_ESC) begin
        mode_nxt = qsed_pkg::MODE_TEXT;
        case (c)
          qsed_pkg::CH_N: begin
            ev_val[ev_n] = qsed_pkg::CH_LF;
            ev_n         = ev_n + 2'd1;
          end
          qsed_pkg::CH_T: begin
            ev_val[ev_n] = qsed_pkg::CH_TAB;
            ev_n         = ev_n + 2'd1;
          end
          qsed_pkg::CH_B: begin
            ev_val[ev_n] = qsed_pkg::CH_BS;
            ev_n         = ev_n + 2'd1;
          end
          qsed_pkg::CH_R: begin
            ev_val[ev_n] = qsed_pkg::CH_CR;
            ev_n         = ev_n + 2'd1;
          end
          qsed_pkg::CH_F: begin
            ev_val[ev_n] = qsed_pkg::CH_FF;
            ev_n         = ev_n + 2'd1;
          end
          qsed_pkg::CH_LF: begin
            // line continuation gives nothing
          end
          default: begin
            if (is_oct) begin
              oct_val_nxt = {5'd0, c[2:0]};
              oct_cnt_nxt = 2'd1;
              mode_nxt    = qsed_pkg::MODE_OCT;
            end else begin
              ev_val[ev_n] = c;
              ev_n         = ev_n + 2'd1;
            end
          end
        endcase
      end else if (mode_nxt == qsed_pkg::MODE_TEXT) begin
        if (c == qsed_pkg::CH_QUOTE) begin
          ev_kind[ev_n] = qsed_pkg::EV_CLOSE;
          ev_n          = ev_n + 2'd1;
          mode_nxt      = qsed_pkg::MODE_IDLE;
          oct_val_nxt   = 8'd0;
          oct_cnt_nxt   = 2'd0;
        end else if (c == qsed_pkg::CH_BSLASH) begin
          mode_nxt = qsed_pkg::MODE_ESC;
        end else begin
          ev_val[ev_n] = c;
          ev_n         = ev_n + 2'd1;
        end
      end
    end

    // end of text: flush pending octal, drop dangling backslash, close
    if (in_chan.string_end && (mode_nxt != qsed_pkg::MODE_IDLE)) begin
      if (mode_nxt == qsed_pkg::MODE_OCT) begin
        ev_kind[ev_n] = qsed_pkg::EV_BYTE;
        ev_val[ev_n]  = oct_val_nxt;
        ev_n          = ev_n + 2'd1;
      end
      ev_kind[ev_n] = qsed_pkg::EV_CLOSE;
      ev_n          = ev_n + 2'd1;
      mode_nxt      = qsed_pkg::MODE_IDLE;
      oct_val_nxt   = 8'd0;
      oct_cnt_nxt   = 2'd0;
    end
  end

  // Length limit: turn events into result records in order
  always_comb begin
    logic [1:0] rn;
    rn       = 2'd0;
    push_run = '0;
    cnt_nxt  = in_chan.string_start ? '0 : cnt_r;
    exc_nxt  = in_chan.string_start ? 1'b0 : exc_r;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < ev_n) begin
        if (ev_kind[i] == qsed_pkg::EV_CLOSE) begin
          push_run.res[rn].end_of_string = 1'b1;
          push_run.res[rn].too_long      = exc_nxt;
          rn                             = rn + 2'd1;
        end else if (cnt_nxt < qsed_pkg::CNT_LIMIT) begin
          cnt_nxt                        = cnt_nxt + 1'b1;
          push_run.res[rn].out_byte      = ev_val[i];
          push_run.res[rn].byte_valid    = 1'b1;
          push_run.res[rn].too_long      = exc_nxt;
          rn                             = rn + 2'd1;
        end else begin
          exc_nxt = 1'b1;
        end
      end
    end
    if (rn != 2'd0) begin
      push_run.res[rn - 2'd1].last_of_run = 1'b1;
    end
    push_run.n = rn;
  end

  assign push = accept && (push_run.n != 2'd0);

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= qsed_pkg::MODE_IDLE;
      oct_val_r <= 8'd0;
      oct_cnt_r <= 2'd0;
      cnt_r     <= '0;
      exc_r     <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      oct_val_r <= oct_val_nxt;
      oct_cnt_r <= oct_cnt_nxt;
      cnt_r     <= cnt_nxt;
      exc_r     <= exc_nxt;
    end
  end

endmodule

// ===== design/qsed_queue.sv =====
// ----------------------------------------------------------------------------
// qsed_queue: result run queue
// Short FIFO of result runs between the classifier and the output stage.
// ----------------------------------------------------------------------------
module qsed_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  qsed_pkg::run_t        push_run,
  input  logic                  pop,
  output qsed_pkg::q_status_t   stat,
  output qsed_pkg::run_t        head
);

  qsed_pkg::run_t                 mem_r [qsed_pkg::QDEPTH];
  logic [qsed_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [qsed_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [qsed_pkg::QPTR_W:0]      count_r, count_nxt;

  assign stat.full  = (count_r == (qsed_pkg::QPTR_W + 1)'(qsed_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ===== design/qsed_back.sv =====
// ----------------------------------------------------------------------------
// qsed_back: output sequencer
// Walks head run results into the output register one per unstalled cycle.
// ----------------------------------------------------------------------------
module qsed_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qsed_pkg::q_status_t   q_stat,
  input  qsed_pkg::run_t        head,
  output logic                  pop,
  qsed_out_if.source            out_chan
);

  logic [1:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  qsed_pkg::res_t    res_r;
  logic              load;

  assign load = !q_stat.empty && (!out_valid_r || out_chan.ready);
  assign pop  = load && (idx_r == (head.n - 2'd1));

  // Result index within the head run, output valid
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = pop ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= head.res[idx_r];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = res_r.out_byte;
  assign out_chan.byte_valid    = res_r.byte_valid;
  assign out_chan.end_of_string = res_r.end_of_string;
  assign out_chan.too_long      = res_r.too_long;
  assign out_chan.last_of_run   = res_r.last_of_run;

endmodule

// ===== design/quoted_string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder: C-style quoted string decoder, top level
// Decodes escapes and octal codes of one quoted token into output bytes.
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  in_chan   in   in_byte, string_start, string_end
//  out_chan  out  out_byte, byte_valid, end_of_string, too_long, last_of_run
//
//  One input byte is taken per cycle while the run queue has room; it gives
//  zero to three results, and the output stage sends one result per cycle
//  while the receiver is ready, so each result of a byte is its own transfer.
//  First result passes the run queue and the output register after its input.
//  Synchronous active-low reset clears mode, counters and queue.
//  Input and output stall independently through the four-run queue.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder (
  input  logic          clk,
  input  logic          rst_n,
  qsed_in_if.sink       in_chan,
  qsed_out_if.source    out_chan
);

  qsed_pkg::q_status_t  q_stat;
  qsed_pkg::run_t       push_run;
  qsed_pkg::run_t       head;
  logic                 push;
  logic                 pop;

  qsed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  qsed_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .stat     (q_stat),
    .head     (head)
  );

  qsed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== sim/quoted_string_escape_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder_tb: self-checking bench for the string decoder
// Feeds quoted tokens (directed corner cases, then random tokens, some malformed,
// mixed with noise) and checks every decoded result record against an
// in-bench decode of the same byte stream, under random stalls on both sides.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_tb;

  localparam int RANDOM_ITEMS = 455;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic [7:0] raw;
    logic       start;
    logic       last;
  } raw_item_t;

  logic clk;
  logic rst_n;

  qsed_in_if  in_if();
  qsed_out_if out_if();

  quoted_string_escape_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Pending token bytes, expected decoded records, bookkeeping
  raw_item_t         token_bytes_q[$];
  qsed_pkg::res_t    decoded_q[$];
  qsed_pkg::res_t    run_buf[$];
  int                total_items;
  int                bytes_sent;
  int                mismatch_count;
  int                cycle_count;

  // Decoder state mirrored by the bench
  qsed_pkg::mode_t dec_mode   = qsed_pkg::MODE_IDLE;
  logic [7:0]      oct_acc    = '0;
  logic [1:0]      oct_digits = '0;
  int unsigned     emitted    = 0;
  logic            overflow   = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit is_oct(logic [7:0] c);
    return (c >= qsed_pkg::CH_0) && (c <= qsed_pkg::CH_7);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Decode prediction
  // ---------------------------------------------------------------------------
  task automatic add_record(logic [7:0] b, logic valid, logic eos);
    qsed_pkg::res_t r;
    r.out_byte      = b;
    r.byte_valid    = valid;
    r.end_of_string = eos;
    r.too_long      = overflow;
    r.last_of_run   = 1'b0;
    run_buf.push_back(r);
  endtask

  // Byte counts toward the length limit; beyond it, dropped and flagged
  task automatic deliver_byte(logic [7:0] b);
    if (emitted < qsed_pkg::MAX_LEN - 1) begin
      emitted++;
      add_record(b, 1'b1, 1'b0);
    end else begin
      overflow = 1'b1;
    end
  endtask

  task automatic close_string();
    add_record(8'h00, 1'b0, 1'b1);
    dec_mode   = qsed_pkg::MODE_IDLE;
    oct_acc    = '0;
    oct_digits = '0;
  endtask

  task automatic decode_char(logic [7:0] c);
    // octal run: absorb a digit, or flush the partial value and fall through
    if (dec_mode == qsed_pkg::MODE_OCT) begin
      if (is_oct(c)) begin
        oct_acc    = {oct_acc[4:0], 3'(c - qsed_pkg::CH_0)};
        oct_digits = oct_digits + 2'd1;
        if (oct_digits == 2'd3) begin
          deliver_byte(oct_acc);
          oct_acc    = '0;
          oct_digits = '0;
          dec_mode   = qsed_pkg::MODE_TEXT;
        end
        return;
      end
      deliver_byte(oct_acc);
      oct_acc    = '0;
      oct_digits = '0;
      dec_mode   = qsed_pkg::MODE_TEXT;
    end
    if (dec_mode == qsed_pkg::MODE_ESC) begin
      dec_mode = qsed_pkg::MODE_TEXT;
      if (c == qsed_pkg::CH_N) deliver_byte(qsed_pkg::CH_LF);
      else if (c == qsed_pkg::CH_T) deliver_byte(qsed_pkg::CH_TAB);
      else if (c == qsed_pkg::CH_B) deliver_byte(qsed_pkg::CH_BS);
      else if (c == qsed_pkg::CH_R) deliver_byte(qsed_pkg::CH_CR);
      else if (c == qsed_pkg::CH_F) deliver_byte(qsed_pkg::CH_FF);
      else if (c == qsed_pkg::CH_LF) begin
        // line continuation gives nothing
      end else if (is_oct(c)) begin
        oct_acc    = 8'(c - qsed_pkg::CH_0);
        oct_digits = 2'd1;
        dec_mode   = qsed_pkg::MODE_OCT;
      end else deliver_byte(c);
      return;
    end
    if (dec_mode == qsed_pkg::MODE_TEXT) begin
      if (c == qsed_pkg::CH_QUOTE) close_string();
      else if (c == qsed_pkg::CH_BSLASH) dec_mode = qsed_pkg::MODE_ESC;
      else deliver_byte(c);
    end
  endtask

  task automatic predict_decode(logic [7:0] c, logic start, logic last);
    run_buf.delete();
    if (start) begin
      dec_mode   = qsed_pkg::MODE_TEXT;
      oct_acc    = '0;
      oct_digits = '0;
      emitted    = 0;
      overflow   = 1'b0;
      if (c != qsed_pkg::CH_QUOTE) decode_char(c);
    end else begin
      decode_char(c);
    end
    if (last && dec_mode != qsed_pkg::MODE_IDLE) begin
      if (dec_mode == qsed_pkg::MODE_OCT) deliver_byte(oct_acc);
      close_string();
    end
    if (run_buf.size() > 0) run_buf[run_buf.size()-1].last_of_run = 1'b1;
    foreach (run_buf[i]) decoded_q.push_back(run_buf[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_raw(logic [7:0] b, logic start, logic last);
    raw_item_t it;
    it.raw   = b;
    it.start = start;
    it.last  = last;
    token_bytes_q.push_back(it);
  endtask

  // One element of token content: a plain byte or an escape sequence
  task automatic push_content();
    logic [7:0] b;
    int sel;
    int digits;
    sel = $urandom_range(0, 19);
    if (sel < 10) begin
      do b = 8'($urandom_range(0, 255));
      while (b == qsed_pkg::CH_QUOTE || b == qsed_pkg::CH_BSLASH);
      push_raw(b, 1'b0, 1'b0);
    end else begin
      push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b0);
      case (sel)
        10: push_raw(qsed_pkg::CH_N, 1'b0, 1'b0);
        11: push_raw(qsed_pkg::CH_T, 1'b0, 1'b0);
        12: push_raw(qsed_pkg::CH_B, 1'b0, 1'b0);
        13: push_raw(qsed_pkg::CH_R, 1'b0, 1'b0);
        14: push_raw(qsed_pkg::CH_F, 1'b0, 1'b0);
        15: push_raw(qsed_pkg::CH_LF, 1'b0, 1'b0);
        16, 17: begin
          digits = $urandom_range(1, 3);
          repeat (digits)
            push_raw(8'(qsed_pkg::CH_0 + $urandom_range(0, 7)), 1'b0, 1'b0);
        end
        18: push_raw(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        default: push_raw(($urandom_range(0, 1) != 0) ? qsed_pkg::CH_QUOTE :
                          qsed_pkg::CH_BSLASH, 1'b0, 1'b0);
      endcase
    end
  endtask

  // A whole token: opening byte, content, then one of several endings
  task automatic push_token(int content_len);
    int ending;
    if ($urandom_range(0, 9) != 0) push_raw(qsed_pkg::CH_QUOTE, 1'b1, 1'b0);
    else push_raw(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    repeat (content_len) push_content();
    ending = $urandom_range(0, 9);
    if (ending < 3) begin
      push_raw(qsed_pkg::CH_QUOTE, 1'b0, 1'b1);
    end else if (ending < 5) begin
      push_raw(qsed_pkg::CH_QUOTE, 1'b0, 1'b0);
      push_raw(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else if (ending < 6) begin
      push_raw(qsed_pkg::CH_QUOTE, 1'b0, 1'b0);
    end else if (ending < 9) begin
      token_bytes_q[token_bytes_q.size()-1].last = 1'b1;
    end
    // else: left open, dropped by the next start
  endtask

  task automatic build_directed();
    push_raw("x", 1'b0, 1'b0);                      // byte outside any string
    push_raw(qsed_pkg::CH_QUOTE, 1'b1, 1'b0);
    push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b0);
    push_raw(qsed_pkg::CH_N, 1'b0, 1'b0);
    push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b0);      // line continuation
    push_raw(qsed_pkg::CH_LF, 1'b0, 1'b0);
    push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b0);      // full octal, wraps past 255
    push_raw("7", 1'b0, 1'b0);
    push_raw("7", 1'b0, 1'b0);
    push_raw("7", 1'b0, 1'b0);
    push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b0);      // two-digit octal cut by a letter
    push_raw("4", 1'b0, 1'b0);
    push_raw("1", 1'b0, 1'b0);
    push_raw("z", 1'b0, 1'b0);
    push_raw(8'h00, 1'b0, 1'b0);                    // zero byte is ordinary data
    push_raw(qsed_pkg::CH_QUOTE, 1'b0, 1'b0);
    push_raw("k", 1'b0, 1'b1);                      // end after close gives nothing
    push_raw("a", 1'b1, 1'b0);                      // start on a non-quote byte
    push_raw("b", 1'b1, 1'b0);                      // restart mid-string
    push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b0);
    push_raw("5", 1'b0, 1'b1);                      // octal cut by end of text
    push_raw(qsed_pkg::CH_QUOTE, 1'b1, 1'b1);       // empty string
    push_raw("q", 1'b1, 1'b0);
    push_raw(qsed_pkg::CH_BSLASH, 1'b0, 1'b1);      // dangling backslash
    push_raw(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic build_random();
    int start_size;
    bit long_done;
    start_size = token_bytes_q.size();
    long_done  = 1'b0;
    while (token_bytes_q.size() - start_size < RANDOM_ITEMS) begin
      if (!long_done && token_bytes_q.size() - start_size > 120) begin
        // overlong token: plain letters well past the length limit
        long_done = 1'b1;
        push_raw(qsed_pkg::CH_QUOTE, 1'b1, 1'b0);
        repeat (qsed_pkg::MAX_LEN + 10)
          push_raw(8'($urandom_range(8'h61, 8'h7A)), 1'b0, 1'b0);
        push_raw(qsed_pkg::CH_QUOTE, 1'b0, 1'b1);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) push_raw(8'($urandom_range(0, 255)), 1'b0,
                                               1'($urandom_range(0, 1)));
      end else begin
        push_token($urandom_range(0, 10));
      end
    end
  endtask

  // Stall percentages for the current phase of the run
  function automatic int send_idle_pct();
    if (bytes_sent * 3 < total_items) return 38;
    if (bytes_sent * 3 < total_items * 2) return 53;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (bytes_sent * 3 < total_items) return 53;
    if (bytes_sent * 3 < total_items * 2) return 38;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: advance on each accepted transaction, predict what it causes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    raw_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_decode(in_if.in_byte, in_if.string_start, in_if.string_end);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (token_bytes_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          nxt = token_bytes_q.pop_front();
          in_if.in_byte      <= nxt.raw;
          in_if.string_start <= nxt.start;
          in_if.string_end   <= nxt.last;
          in_if.valid        <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted record with the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    qsed_pkg::res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected record", 32'(out_if.out_byte), 32'd0);
        end else begin
          want = decoded_q.pop_front();
          if (out_if.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(out_if.out_byte), 32'(want.out_byte));
          if (out_if.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(out_if.byte_valid),
                            32'(want.byte_valid));
          if (out_if.end_of_string !== want.end_of_string)
            report_mismatch("end_of_string", 32'(out_if.end_of_string),
                            32'(want.end_of_string));
          if (out_if.too_long !== want.too_long)
            report_mismatch("too_long", 32'(out_if.too_long), 32'(want.too_long));
          if (out_if.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(out_if.last_of_run),
                            32'(want.last_of_run));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, stimulus fill and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cycle_count        = 0;
    bytes_sent         = 0;
    mismatch_count     = 0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = 8'h00;
    in_if.string_start = 1'b0;
    in_if.string_end   = 1'b0;
    out_if.ready       = 1'b0;

    build_directed();
    build_random();
    total_items = token_bytes_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (token_bytes_q.size() > 0 || in_if.valid) @(posedge clk);
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/qsed_pkg.sv
design/qsed_in_if.sv
design/qsed_out_if.sv
design/qsed_front.sv
design/qsed_queue.sv
design/qsed_back.sv
design/quoted_string_escape_decoder.sv
sim/quoted_string_escape_decoder_tb.sv
